// ----- src/ffa_pkg.sv -----
package ffa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int UNIT_BYTES = 32;

  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int BLK_SHIFT = $clog2(UNIT_BYTES);
  localparam int NEED_W    = CNT_W + 1;

  localparam int OPCODE_W = 1;
  localparam int REQ_W    = 14;
  localparam int OFF_W    = 13;
  localparam int STATUS_W = 2;
  localparam int FREED_W  = 9;
  localparam int FBYTES_W = 14;

  localparam int MAP_W         = 2;
  localparam int MAP_ALLOC_BIT = 0;
  localparam int MAP_HEAD_BIT  = 1;
  localparam logic [MAP_W-1:0] MAP_BODY = 2'b01;
  localparam logic [MAP_W-1:0] MAP_HEAD = 2'b11;

  localparam logic [OPCODE_W-1:0] OP_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      mark;
    logic      free_rd;
    logic      free_chk;
    logic      resp;
    logic      status_we;
    status_e_t status_val;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_bad;
    logic size_short;
    logic scan_hit;
    logic scan_end;
    logic mark_last;
    logic walk_stop;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

// ----- src/ffa_ram.sv -----
module ffa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/ffa_datapath.sv -----
module ffa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffa_pkg::cmd_t                 cmd,
  output ffa_pkg::sts_t                 sts,
  input  logic [ffa_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ffa_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]     in_free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffa_pkg::STATUS_W-1:0]  out_status,
  output logic [ffa_pkg::OFF_W-1:0]     out_offset_bytes,
  output logic [ffa_pkg::FREED_W-1:0]   out_freed_blocks,
  output logic [ffa_pkg::FBYTES_W-1:0]  out_free_bytes
);

  localparam logic [ffa_pkg::IDX_W-1:0] LAST_IDX = ffa_pkg::IDX_W'(ffa_pkg::NUM_BLOCKS - 1);

  logic [ffa_pkg::NUM_BLOCKS-1:0] valid_r;
  logic [ffa_pkg::CNT_W-1:0]      free_count_r;
  logic                           out_valid_r;

  logic [ffa_pkg::OPCODE_W-1:0]   op_r;
  logic [ffa_pkg::NEED_W-1:0]     need_r;
  logic                           zero_req_r;
  logic [ffa_pkg::IDX_W-1:0]      idx_r;
  logic                           first_r;
  logic [ffa_pkg::FREED_W-1:0]    freed_r;
  logic [ffa_pkg::IDX_W-1:0]      start_r;
  logic [ffa_pkg::IDX_W-1:0]      scan_idx_r;
  logic                           issued_all_r;
  logic                           pipe_v_r;
  logic [ffa_pkg::IDX_W-1:0]      chk_idx_r;
  logic [ffa_pkg::CNT_W-1:0]      run_r;
  logic [ffa_pkg::IDX_W-1:0]      mark_idx_r;
  logic [ffa_pkg::IDX_W-1:0]      mark_cnt_r;
  ffa_pkg::status_e_t             status_r;
  logic                           valid_q_r;

  logic [ffa_pkg::STATUS_W-1:0]   o_status_r;
  logic [ffa_pkg::OFF_W-1:0]      o_offset_r;
  logic [ffa_pkg::FREED_W-1:0]    o_freed_r;
  logic [ffa_pkg::FBYTES_W-1:0]   o_fbytes_r;

  logic [ffa_pkg::NEED_W-1:0]     need_nxt;
  logic                           rd_en;
  logic [ffa_pkg::IDX_W-1:0]      rd_addr;
  logic [ffa_pkg::MAP_W-1:0]      ram_rdata;
  logic [ffa_pkg::MAP_W-1:0]      entry;
  logic [ffa_pkg::CNT_W-1:0]      run_nxt;
  logic [ffa_pkg::CNT_W-1:0]      start_wide;
  logic                           hit;
  logic                           stop;
  logic [ffa_pkg::MAP_W-1:0]      wr_data;

  assign need_nxt = ffa_pkg::NEED_W'(in_request_bytes[ffa_pkg::REQ_W-1:ffa_pkg::BLK_SHIFT])
                  + ffa_pkg::NEED_W'(|in_request_bytes[ffa_pkg::BLK_SHIFT-1:0]);

  assign rd_en   = (cmd.scan && !issued_all_r) || cmd.free_rd;
  assign rd_addr = cmd.free_rd ? idx_r : scan_idx_r;
  assign wr_data = (mark_idx_r == start_r) ? ffa_pkg::MAP_HEAD : ffa_pkg::MAP_BODY;

  ffa_ram #(
    .WIDTH (ffa_pkg::MAP_W),
    .DEPTH (ffa_pkg::NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (cmd.mark),
    .waddr (mark_idx_r),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign entry = valid_q_r ? ram_rdata : '0;

  always_comb begin
    run_nxt    = entry[ffa_pkg::MAP_ALLOC_BIT] ? '0 : run_r + 1'b1;
    hit        = pipe_v_r && (ffa_pkg::NEED_W'(run_nxt) == need_r);
    start_wide = ffa_pkg::CNT_W'(chk_idx_r) + 1'b1 - run_nxt;
    stop       = !entry[ffa_pkg::MAP_ALLOC_BIT]
              || (first_r ? !entry[ffa_pkg::MAP_HEAD_BIT] : entry[ffa_pkg::MAP_HEAD_BIT]);
  end

  always_comb begin
    sts.op_free    = (op_r == ffa_pkg::OP_FREE);
    sts.size_bad   = zero_req_r || (need_r >= ffa_pkg::NEED_W'(ffa_pkg::NUM_BLOCKS));
    sts.size_short = need_r > ffa_pkg::NEED_W'(free_count_r);
    sts.scan_hit   = hit;
    sts.scan_end   = pipe_v_r && !hit && (chk_idx_r == LAST_IDX);
    sts.mark_last  = (mark_cnt_r == ffa_pkg::IDX_W'(1));
    sts.walk_stop  = stop;
    sts.walk_last  = (idx_r == LAST_IDX);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      free_count_r <= ffa_pkg::CNT_W'(ffa_pkg::NUM_BLOCKS);
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.mark) begin
        valid_r[mark_idx_r] <= 1'b1;
        free_count_r        <= free_count_r - 1'b1;
      end else if (cmd.free_chk && !stop) begin
        valid_r[idx_r] <= 1'b0;
        free_count_r   <= free_count_r + 1'b1;
      end
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      valid_q_r <= valid_r[rd_addr];
    end
    if (cmd.load) begin
      op_r         <= in_opcode;
      need_r       <= need_nxt;
      zero_req_r   <= (in_request_bytes == '0);
      idx_r        <= in_free_offset[ffa_pkg::OFF_W-1:ffa_pkg::BLK_SHIFT];
      first_r      <= 1'b1;
      freed_r      <= '0;
      start_r      <= '0;
      scan_idx_r   <= '0;
      issued_all_r <= 1'b0;
      pipe_v_r     <= 1'b0;
      run_r        <= '0;
      status_r     <= ffa_pkg::ST_OK;
    end else begin
      if (cmd.status_we) begin
        status_r <= cmd.status_val;
      end
      if (cmd.scan) begin
        pipe_v_r <= !issued_all_r;
        if (!issued_all_r) begin
          chk_idx_r  <= scan_idx_r;
          scan_idx_r <= scan_idx_r + 1'b1;
          if (scan_idx_r == LAST_IDX) begin
            issued_all_r <= 1'b1;
          end
        end
        if (pipe_v_r) begin
          run_r <= run_nxt;
        end
        if (hit) begin
          start_r    <= start_wide[ffa_pkg::IDX_W-1:0];
          mark_idx_r <= start_wide[ffa_pkg::IDX_W-1:0];
          mark_cnt_r <= need_r[ffa_pkg::IDX_W-1:0];
        end
      end
      if (cmd.mark) begin
        mark_idx_r <= mark_idx_r + 1'b1;
        mark_cnt_r <= mark_cnt_r - 1'b1;
      end
      if (cmd.free_chk && !stop) begin
        freed_r <= freed_r + 1'b1;
        first_r <= 1'b0;
        idx_r   <= idx_r + 1'b1;
      end
    end
    if (cmd.resp) begin
      o_status_r <= status_r;
      o_offset_r <= ffa_pkg::OFF_W'({start_r, ffa_pkg::BLK_SHIFT'(0)});
      o_freed_r  <= freed_r;
      o_fbytes_r <= ffa_pkg::FBYTES_W'({free_count_r, ffa_pkg::BLK_SHIFT'(0)});
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_offset_bytes = o_offset_r;
  assign out_freed_blocks = o_freed_r;
  assign out_free_bytes   = o_fbytes_r;

endmodule

// ----- src/ffa_ctrl.sv -----
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);

  ffa_pkg::state_t state_r;
  ffa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ffa_pkg::S_DECODE;
        end
      end
      ffa_pkg::S_DECODE: begin
        priority if (sts.op_free) begin
          state_nxt = ffa_pkg::S_FREE_RD;
        end else if (sts.size_bad || sts.size_short) begin
          state_nxt = ffa_pkg::S_RESP;
        end else begin
          state_nxt = ffa_pkg::S_SCAN;
        end
      end
      ffa_pkg::S_SCAN: begin
        if (sts.scan_hit) begin
          state_nxt = ffa_pkg::S_MARK;
        end else if (sts.scan_end) begin
          state_nxt = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_MARK: begin
        if (sts.mark_last) begin
          state_nxt = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_FREE_RD: begin
        state_nxt = ffa_pkg::S_FREE_CHK;
      end
      ffa_pkg::S_FREE_CHK: begin
        if (sts.walk_stop || sts.walk_last) begin
          state_nxt = ffa_pkg::S_RESP;
        end else begin
          state_nxt = ffa_pkg::S_FREE_RD;
        end
      end
      ffa_pkg::S_RESP: begin
        if (sts.out_free) begin
          state_nxt = ffa_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.status_val = ffa_pkg::ST_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ffa_pkg::S_DECODE: begin
        priority if (sts.op_free) begin
          cmd.status_we = 1'b0;
        end else if (sts.size_bad) begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ffa_pkg::ST_BAD;
        end else if (sts.size_short) begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ffa_pkg::ST_NOSPACE;
        end else begin
          cmd.status_we = 1'b0;
        end
      end
      ffa_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          cmd.status_we  = 1'b1;
          cmd.status_val = ffa_pkg::ST_NOSPACE;
        end
      end
      ffa_pkg::S_MARK:     cmd.mark     = 1'b1;
      ffa_pkg::S_FREE_RD:  cmd.free_rd  = 1'b1;
      ffa_pkg::S_FREE_CHK: cmd.free_chk = 1'b1;
      ffa_pkg::S_RESP:     cmd.resp     = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/first_fit_block_allocator_unit.sv -----
// Allocate scans the map from block 0 for the first free run long enough, then marks it
//   (bad or oversized sizes skip the scan); a failed scan covers all 256 blocks.
// Free examines map entries one at a time, at most 256 of them.
// Throughput: one word at a time; the next word is accepted the cycle after the result
//   is loaded into the output register, which waits while an earlier result is held.
// Reset: synchronous, active low; per-block flags make every block read free at once.
module first_fit_block_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffa_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ffa_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]     in_free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffa_pkg::STATUS_W-1:0]  out_status,
  output logic [ffa_pkg::OFF_W-1:0]     out_offset_bytes,
  output logic [ffa_pkg::FREED_W-1:0]   out_freed_blocks,
  output logic [ffa_pkg::FBYTES_W-1:0]  out_free_bytes
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_offset_bytes (out_offset_bytes),
    .out_freed_blocks (out_freed_blocks),
    .out_free_bytes   (out_free_bytes)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while busy");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffa_pkg::ST_OK) |->
      (out_offset_bytes == '0 && out_freed_blocks == '0))
    else $error("failed request reports allocation or free");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_free_bytes <= ffa_pkg::FBYTES_W'(ffa_pkg::NUM_BLOCKS * ffa_pkg::UNIT_BYTES)))
    else $error("free byte count exceeds pool");

endmodule

// ----- tb/first_fit_block_allocator_unit_tb.sv -----
module first_fit_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ffa_pkg::OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam int CYCLE_LIMIT    = 4000000;
  localparam int TAIL_CYCLES    = 600;
  localparam int RX_HOLD_CYCLES = 2000;
  localparam int MAX_REQ        = (1 << ffa_pkg::REQ_W) - 1;
  localparam int MAX_OFF        = (1 << ffa_pkg::OFF_W) - 1;

  typedef struct packed {
    logic [ffa_pkg::STATUS_W-1:0] status;
    logic [ffa_pkg::OFF_W-1:0]    offset;
    logic [ffa_pkg::FREED_W-1:0]  freed;
    logic [ffa_pkg::FBYTES_W-1:0] free_bytes;
  } pool_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [ffa_pkg::OPCODE_W-1:0] in_opcode;
  logic [ffa_pkg::REQ_W-1:0]    in_request_bytes;
  logic [ffa_pkg::OFF_W-1:0]    in_free_offset;
  logic                         out_valid;
  logic                         out_ready;
  logic [ffa_pkg::STATUS_W-1:0] out_status;
  logic [ffa_pkg::OFF_W-1:0]    out_offset_bytes;
  logic [ffa_pkg::FREED_W-1:0]  out_freed_blocks;
  logic [ffa_pkg::FBYTES_W-1:0] out_free_bytes;

  logic [ffa_pkg::MAP_W-1:0] pool_map [ffa_pkg::NUM_BLOCKS];
  int                        pool_free_blocks;
  pool_result_t              pending_results [$];
  int                        mismatches = 0;
  bit                        no_idle = 1'b0;
  bit                        rx_hold_req = 1'b0;

  first_fit_block_allocator_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_offset_bytes (out_offset_bytes),
    .out_freed_blocks (out_freed_blocks),
    .out_free_bytes   (out_free_bytes)
  );

  always #5 clk = ~clk;

  // Applies one request to the pool image and returns the word it must produce.
  function automatic pool_result_t apply_to_pool(logic [ffa_pkg::OPCODE_W-1:0] op,
                                                 logic [ffa_pkg::REQ_W-1:0] req,
                                                 logic [ffa_pkg::OFF_W-1:0] off);
    pool_result_t r;
    int need;
    int run;
    int start;
    int idx;
    int n;
    bit found;
    r = '0;
    r.status = ffa_pkg::ST_OK;
    if (op == ffa_pkg::OP_FREE) begin
      idx = int'(off) / ffa_pkg::UNIT_BYTES;
      if (idx >= ffa_pkg::NUM_BLOCKS) begin
        r.status = ffa_pkg::ST_BAD;
      end else begin
        n = 0;
        for (int i = idx; i < ffa_pkg::NUM_BLOCKS; i++) begin
          if (!pool_map[i][ffa_pkg::MAP_ALLOC_BIT]) break;
          if ((i == idx) ? !pool_map[i][ffa_pkg::MAP_HEAD_BIT]
                         : pool_map[i][ffa_pkg::MAP_HEAD_BIT]) break;
          pool_map[i] = '0;
          n++;
        end
        pool_free_blocks += n;
        r.freed = ffa_pkg::FREED_W'(n);
      end
    end else begin
      need = (int'(req) + ffa_pkg::UNIT_BYTES - 1) / ffa_pkg::UNIT_BYTES;
      if (req == 0 || need >= ffa_pkg::NUM_BLOCKS) begin
        r.status = ffa_pkg::ST_BAD;
      end else if (need > pool_free_blocks) begin
        r.status = ffa_pkg::ST_NOSPACE;
      end else begin
        run = 0;
        start = 0;
        found = 1'b0;
        for (int i = 0; i < ffa_pkg::NUM_BLOCKS && !found; i++) begin
          if (pool_map[i][ffa_pkg::MAP_ALLOC_BIT]) run = 0;
          else run++;
          if (run == need) begin
            start = i + 1 - run;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ffa_pkg::ST_NOSPACE;
        end else begin
          for (int i = start; i < start + need; i++)
            pool_map[i] = (i == start) ? ffa_pkg::MAP_HEAD : ffa_pkg::MAP_BODY;
          pool_free_blocks -= need;
          r.offset = ffa_pkg::OFF_W'(start * ffa_pkg::UNIT_BYTES);
        end
      end
    end
    r.free_bytes = ffa_pkg::FBYTES_W'(pool_free_blocks * ffa_pkg::UNIT_BYTES);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ffa_pkg::OFF_W-1:0] pick_run_offset();
    int heads [$];
    int sel;
    for (int i = 0; i < ffa_pkg::NUM_BLOCKS; i++)
      if (pool_map[i] == ffa_pkg::MAP_HEAD) heads.push_back(i);
    if (heads.size() == 0) return ffa_pkg::OFF_W'($urandom_range(0, MAX_OFF));
    sel = heads[$urandom_range(0, heads.size() - 1)];
    return ffa_pkg::OFF_W'(sel * ffa_pkg::UNIT_BYTES
                           + $urandom_range(0, ffa_pkg::UNIT_BYTES - 1));
  endfunction

  function automatic logic [ffa_pkg::REQ_W-1:0] pick_request_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ffa_pkg::REQ_W'($urandom_range(1, 256));
    if (r < 85) return ffa_pkg::REQ_W'($urandom_range(257, 2048));
    if (r < 95)
      return ffa_pkg::REQ_W'($urandom_range(2049, ffa_pkg::NUM_BLOCKS * ffa_pkg::UNIT_BYTES));
    return ffa_pkg::REQ_W'($urandom_range(0, MAX_REQ));
  endfunction

  task automatic flag_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", field, want, got);
  endtask

  // Offers one word, returns right after the edge that accepts it.
  task automatic offer_request(logic [ffa_pkg::OPCODE_W-1:0] op,
                               logic [ffa_pkg::REQ_W-1:0] req,
                               logic [ffa_pkg::OFF_W-1:0] off);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode        <= op;
    in_request_bytes <= req;
    in_free_offset   <= off;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_to_pool(op, req, off));
  endtask

  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("word with nothing pending, status", -1, int'(out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", int'(want.status), int'(out_status));
        if (out_offset_bytes !== want.offset)
          flag_mismatch("offset_bytes", int'(want.offset), int'(out_offset_bytes));
        if (out_freed_blocks !== want.freed)
          flag_mismatch("freed_blocks", int'(want.freed), int'(out_freed_blocks));
        if (out_free_bytes !== want.free_bytes)
          flag_mismatch("free_bytes", int'(want.free_bytes), int'(out_free_bytes));
      end
    end
  end

  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("first_fit_block_allocator_unit_tb: errors");
    $finish;
  end

  task automatic test_size_limits();
    offer_request(OP_ALLOC, 14'd0, ffa_pkg::OFF_W'(MAX_OFF));
    offer_request(OP_ALLOC, 14'd8192, '0);
    offer_request(OP_ALLOC, 14'd8161, '0);
    offer_request(OP_ALLOC, ffa_pkg::REQ_W'(MAX_REQ), '0);
    offer_request(OP_ALLOC, 14'd8160, '0);
    offer_request(OP_ALLOC, 14'd33, '0);
    offer_request(OP_ALLOC, 14'd32, '0);
    offer_request(OP_ALLOC, 14'd1, '0);
    offer_request(ffa_pkg::OP_FREE, ffa_pkg::REQ_W'(MAX_REQ), 13'd8165);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd31);
  endtask

  task automatic test_run_boundaries();
    offer_request(OP_ALLOC, 14'd1, '0);
    offer_request(OP_ALLOC, 14'd33, '0);
    offer_request(OP_ALLOC, 14'd64, '0);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd64);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd32);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd40);
    offer_request(OP_ALLOC, 14'd8096, '0);
    offer_request(OP_ALLOC, 14'd96, '0);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd0);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd96);
    offer_request(ffa_pkg::OP_FREE, '0, 13'd160);
  endtask

  // Mostly real runs being carved and released; some junk words mixed in.
  task automatic test_random_traffic(int count);
    int r;
    int free_pct;
    logic [ffa_pkg::OPCODE_W-1:0] op;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        offer_request(ffa_pkg::OPCODE_W'($urandom_range(0, 1)),
                      ffa_pkg::REQ_W'($urandom_range(0, MAX_REQ)),
                      ffa_pkg::OFF_W'($urandom_range(0, MAX_OFF)));
      end else begin
        if (pool_free_blocks < 48) free_pct = 70;
        else if (pool_free_blocks > 200) free_pct = 20;
        else free_pct = 45;
        op = ($urandom_range(0, 99) < free_pct) ? ffa_pkg::OP_FREE : OP_ALLOC;
        if (op == OP_ALLOC)
          offer_request(OP_ALLOC, pick_request_bytes(),
                        ffa_pkg::OFF_W'($urandom_range(0, MAX_OFF)));
        else if ($urandom_range(0, 9) == 0)
          offer_request(ffa_pkg::OP_FREE, ffa_pkg::REQ_W'($urandom_range(0, MAX_REQ)),
                        ffa_pkg::OFF_W'($urandom_range(0, MAX_OFF)));
        else
          offer_request(ffa_pkg::OP_FREE, ffa_pkg::REQ_W'($urandom_range(0, MAX_REQ)),
                        pick_run_offset());
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_random_traffic(count);
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    rx_hold_req = 1'b1;
    test_random_traffic(30);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_ALLOC;
    in_request_bytes = '0;
    in_free_offset   = '0;
    for (int i = 0; i < ffa_pkg::NUM_BLOCKS; i++) pool_map[i] = '0;
    pool_free_blocks = ffa_pkg::NUM_BLOCKS;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_size_limits();
    test_run_boundaries();
    test_random_traffic(800);
    test_back_to_back(250);
    test_output_backpressure();
    test_random_traffic(150);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("first_fit_block_allocator_unit_tb: clean");
    else
      $display("first_fit_block_allocator_unit_tb: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_datapath.sv
src/ffa_ctrl.sv
src/first_fit_block_allocator_unit.sv
tb/first_fit_block_allocator_unit_tb.sv
